/* hw/rtl/udrb_pkg.sv */
package udrb_pkg;

  // ring geometry
  localparam int RingDepth = 256;
  localparam int PtrW      = $clog2(RingDepth);
  localparam int DataW     = 8;
  localparam int LevelW    = 8;
  localparam int OpW       = 2;

  typedef logic [PtrW-1:0]   ptr_t;
  typedef logic [PtrW:0]     ptr_ext_t;
  typedef logic [DataW-1:0]  data_t;
  typedef logic [LevelW-1:0] level_t;

  typedef enum logic [OpW-1:0] {
    OP_HOST_WRITE = 2'd0,
    OP_HOST_READ  = 2'd1,
    OP_LINE_RX    = 2'd2,
    OP_LINE_DONE  = 2'd3
  } op_e;

  // next slot, wrapping at the ring depth
  function automatic ptr_t ring_next(ptr_t p);
    ring_next = (p == ptr_t'(RingDepth - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  // occupancy between tail and head
  function automatic ptr_t ring_level(ptr_t head, ptr_t tail);
    ptr_ext_t sum;
    sum = {1'b0, head} + ptr_ext_t'(RingDepth) - {1'b0, tail};
    if (sum >= ptr_ext_t'(RingDepth)) begin
      sum = sum - ptr_ext_t'(RingDepth);
    end
    ring_level = sum[PtrW-1:0];
  endfunction

endpackage

/* hw/rtl/udrb_if.sv */
interface udrb_in_if import udrb_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [OpW-1:0] op;
  data_t         data_in;

  modport source (output valid, output op, output data_in, input ready);
  modport sink   (input valid, input op, input data_in, output ready);
endinterface

interface udrb_out_if import udrb_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   ok;
  data_t  read_byte;
  logic   line_tx_valid;
  data_t  line_tx_byte;
  level_t tx_level;
  level_t rx_level;

  modport source (
    output valid, output ok, output read_byte, output line_tx_valid,
    output line_tx_byte, output tx_level, output rx_level, input ready
  );
  modport sink (
    input valid, input ok, input read_byte, input line_tx_valid,
    input line_tx_byte, input tx_level, input rx_level, output ready
  );
endinterface

/* hw/rtl/uart_dual_ring_buffer.sv */
// uart byte buffer with a transmit ring and a receive ring
//
// in_i carries one request per handshake: op selects host write, host read,
// line byte received or line transmit done; data_in is the byte for a host
// write or a received line byte. out_o returns exactly one result for every
// request: ok, the byte read by the host, the byte handed to the line
// transmitter (with its valid flag) and both fill levels after the request.
//
// the result is registered: it is on out_o right after the accepting edge
// and can leave at the next edge. one request is taken per cycle while out_o
// is ready; each request reads at most one entry of one ring memory, sampled
// at the accepting edge and registered.
// pointers and the transmitter idle flag update at the accepting edge, so the
// next request sees them at once; a request only ever writes or reads one
// ring, so no write and read of the same entry can meet in one cycle.
//
// reset clears the four pointers, empties the result stage and sets the
// transmitter idle; ring contents are not cleared. when out_o is stalled the
// result and the memory read data hold, and in_i stops taking requests until
// the result leaves.
module uart_dual_ring_buffer import udrb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  udrb_in_if.sink    in_i,
  udrb_out_if.source out_o
);

  // ring memories
  data_t tx_mem [RingDepth];
  data_t rx_mem [RingDepth];
  data_t tx_rdata_q;
  data_t rx_rdata_q;

  // ring control
  ptr_t tx_head_q, tx_head_d;
  ptr_t tx_tail_q, tx_tail_d;
  ptr_t rx_head_q, rx_head_d;
  ptr_t rx_tail_q, rx_tail_d;
  logic tx_idle_q, tx_idle_d;

  // result stage
  logic   res_valid_q;
  logic   res_ok_q, res_ok_d;
  logic   res_rd_q, res_rd_d;       // host read returned data
  logic   res_txv_q, res_txv_d;     // byte handed to the line
  logic   res_txmem_q, res_txmem_d; // that byte comes from the ring memory
  data_t  res_data_q;
  level_t res_tx_lvl_q, res_rx_lvl_q;

  logic accept;
  op_e  op;
  ptr_t tx_lvl;
  logic tx_we, tx_re, rx_we, rx_re;

  assign op     = op_e'(in_i.op);
  assign accept = in_i.valid && in_i.ready;
  assign tx_lvl = ring_level(tx_head_q, tx_tail_q);

  // result leaves or stage is empty: take the next request
  assign in_i.ready = !res_valid_q || out_o.ready;

  always_comb begin
    tx_head_d   = tx_head_q;
    tx_tail_d   = tx_tail_q;
    rx_head_d   = rx_head_q;
    rx_tail_d   = rx_tail_q;
    tx_idle_d   = tx_idle_q;
    res_ok_d    = 1'b0;
    res_rd_d    = 1'b0;
    res_txv_d   = 1'b0;
    res_txmem_d = 1'b0;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    unique case (op)
      OP_HOST_WRITE: begin
        // refuse when two or fewer slots are free
        if (tx_lvl < ptr_t'(RingDepth - 2)) begin
          tx_we     = 1'b1;
          tx_head_d = ring_next(tx_head_q);
          res_ok_d  = 1'b1;
          if (tx_idle_q) begin
            // idle means the ring was empty: the new byte goes straight out
            tx_idle_d = 1'b0;
            res_txv_d = 1'b1;
            tx_tail_d = ring_next(tx_tail_q);
          end
        end
      end
      OP_HOST_READ: begin
        if (rx_head_q != rx_tail_q) begin
          rx_re     = 1'b1;
          rx_tail_d = ring_next(rx_tail_q);
          res_ok_d  = 1'b1;
          res_rd_d  = 1'b1;
        end
      end
      OP_LINE_RX: begin
        // keep one slot open so full and empty stay apart
        if (ring_next(rx_head_q) != rx_tail_q) begin
          rx_we     = 1'b1;
          rx_head_d = ring_next(rx_head_q);
          res_ok_d  = 1'b1;
        end
      end
      OP_LINE_DONE: begin
        if (tx_head_q != tx_tail_q) begin
          tx_re       = 1'b1;
          tx_tail_d   = ring_next(tx_tail_q);
          res_txv_d   = 1'b1;
          res_txmem_d = 1'b1;
        end else begin
          tx_idle_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // transmit ring memory
  always_ff @(posedge clk_i) begin
    if (accept && tx_we) begin
      tx_mem[tx_head_q] <= in_i.data_in;
    end
    if (accept && tx_re) begin
      tx_rdata_q <= tx_mem[tx_tail_q];
    end
  end

  // receive ring memory
  always_ff @(posedge clk_i) begin
    if (accept && rx_we) begin
      rx_mem[rx_head_q] <= in_i.data_in;
    end
    if (accept && rx_re) begin
      rx_rdata_q <= rx_mem[rx_tail_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      tx_idle_q   <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        tx_head_q <= tx_head_d;
        tx_tail_q <= tx_tail_d;
        rx_head_q <= rx_head_d;
        rx_tail_q <= rx_tail_d;
        tx_idle_q <= tx_idle_d;
      end
      if (in_i.ready) begin
        res_valid_q <= in_i.valid;
      end
    end
  end

  // result payload, loaded only with a new request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_ok_q     <= res_ok_d;
      res_rd_q     <= res_rd_d;
      res_txv_q    <= res_txv_d;
      res_txmem_q  <= res_txmem_d;
      res_data_q   <= in_i.data_in;
      res_tx_lvl_q <= level_t'(ring_level(tx_head_d, tx_tail_d));
      res_rx_lvl_q <= level_t'(ring_level(rx_head_d, rx_tail_d));
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.ok            = res_ok_q;
  assign out_o.read_byte     = res_rd_q ? rx_rdata_q : '0;
  assign out_o.line_tx_valid = res_txv_q;
  assign out_o.line_tx_byte  = !res_txv_q ? '0 : (res_txmem_q ? tx_rdata_q : res_data_q);
  assign out_o.tx_level      = res_tx_lvl_q;
  assign out_o.rx_level      = res_rx_lvl_q;

`ifndef SYNTH
  // an idle transmitter always has an empty ring
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_idle_q |-> (tx_head_q == tx_tail_q))
    else $error("transmitter idle with bytes pending");

  // transmit ring never goes past two free slots
  a_tx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_lvl <= ptr_t'(RingDepth - 2))
    else $error("transmit ring overfilled");

  // a refused write leaves the transmit head alone
  a_refuse_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_HOST_WRITE && tx_lvl >= ptr_t'(RingDepth - 2))
    |=> ($stable(tx_head_q) && !res_ok_q))
    else $error("refused write changed the ring");

  // a read from an empty receive ring fails
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_HOST_READ && rx_head_q == rx_tail_q)
    |=> (!res_ok_q && $stable(rx_tail_q)))
    else $error("read from empty ring succeeded");
`endif

endmodule

/* test/udrb_ring_monitor.sv */
`timescale 1ns / 1ps

module udrb_ring_monitor import udrb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  udrb_in_if   in_i,
  udrb_out_if  out_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   checked_o,
  output int   refused_o,
  output int   dropped_o
);

  typedef struct packed {
    logic   ok;
    data_t  read_byte;
    logic   line_tx_valid;
    data_t  line_tx_byte;
    level_t tx_level;
    level_t rx_level;
  } uart_result_t;

  // shadow copy of both rings
  data_t tx_ring [RingDepth];
  data_t rx_ring [RingDepth];
  ptr_t  tx_wr, tx_rd, rx_wr, rx_rd;
  logic  tx_quiet;

  uart_result_t awaited_results [$];
  int mismatches = 0;
  int checked    = 0;
  int refused    = 0;
  int dropped    = 0;

  function automatic ptr_t wrap_inc(ptr_t p);
    return ptr_t'((int'(p) + 1) % RingDepth);
  endfunction

  function automatic int fill_of(ptr_t wr, ptr_t rd);
    return (int'(wr) - int'(rd) + RingDepth) % RingDepth;
  endfunction

  // next byte to the line, or the transmitter goes quiet
  function automatic void hand_next_byte(inout uart_result_t r);
    if (tx_wr != tx_rd) begin
      r.line_tx_valid = 1'b1;
      r.line_tx_byte  = tx_ring[tx_rd];
      tx_rd           = wrap_inc(tx_rd);
    end else begin
      tx_quiet = 1'b1;
    end
  endfunction

  function automatic uart_result_t predict_request(op_e op, data_t b);
    uart_result_t r;
    r = '0;
    case (op)
      OP_HOST_WRITE: begin
        // refused once only two slots are left
        if (RingDepth - fill_of(tx_wr, tx_rd) > 2) begin
          tx_ring[tx_wr] = b;
          tx_wr          = wrap_inc(tx_wr);
          r.ok           = 1'b1;
          if (tx_quiet) begin
            tx_quiet = 1'b0;
            hand_next_byte(r);
          end
        end else begin
          refused++;
        end
      end
      OP_HOST_READ: begin
        if (rx_wr != rx_rd) begin
          r.read_byte = rx_ring[rx_rd];
          rx_rd       = wrap_inc(rx_rd);
          r.ok        = 1'b1;
        end
      end
      OP_LINE_RX: begin
        if (wrap_inc(rx_wr) != rx_rd) begin
          rx_ring[rx_wr] = b;
          rx_wr          = wrap_inc(rx_wr);
          r.ok           = 1'b1;
        end else begin
          dropped++;
        end
      end
      default: begin
        hand_next_byte(r);
      end
    endcase
    r.tx_level = level_t'(fill_of(tx_wr, tx_rd));
    r.rx_level = level_t'(fill_of(rx_wr, rx_rd));
    return r;
  endfunction

  task automatic report_failure(string msg);
    if (mismatches < 40) begin
      $display("[%0t] ring monitor: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_failure($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    uart_result_t want;
    if (!rst_ni) begin
      tx_wr    = '0;
      tx_rd    = '0;
      rx_wr    = '0;
      rx_rd    = '0;
      tx_quiet = 1'b1;
      awaited_results.delete();
    end else begin
      // results first: a request accepted now cannot answer on this edge
      if (out_i.valid && out_i.ready) begin
        checked++;
        if (awaited_results.size() == 0) begin
          report_failure("result arrived with no request outstanding");
        end else begin
          want = awaited_results.pop_front();
          check_field("ok", 8'(out_i.ok), 8'(want.ok));
          check_field("read_byte", out_i.read_byte, want.read_byte);
          check_field("line_tx_valid", 8'(out_i.line_tx_valid), 8'(want.line_tx_valid));
          check_field("line_tx_byte", out_i.line_tx_byte, want.line_tx_byte);
          check_field("tx_level", out_i.tx_level, want.tx_level);
          check_field("rx_level", out_i.rx_level, want.rx_level);
        end
      end
      if (in_i.valid && in_i.ready) begin
        awaited_results.push_back(predict_request(op_e'(in_i.op), in_i.data_in));
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= awaited_results.size();
    checked_o    <= checked;
    refused_o    <= refused;
    dropped_o    <= dropped;
  end

endmodule

/* test/tb_uart_dual_ring_buffer.sv */
`timescale 1ns / 1ps

module tb_uart_dual_ring_buffer;
  import udrb_pkg::*;

  // cycles without any request or result before the run is declared hung
  localparam int HangLimit   = 4000;
  // drain time after the last result
  localparam int TailCycles  = 10;
  // enough traffic to overflow both rings from empty
  localparam int FillBytes   = 260;
  localparam int PhaseItems  = 170;

  typedef enum int {
    MIX_UNIFORM,
    MIX_FILL,
    MIX_DRAIN,
    MIX_STREAM
  } burst_mix_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // pacing knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int sent_by_op [4] = '{default: 0};
  int quiet_cycles = 0;

  int mismatches, pending, checked, refused, dropped;

  udrb_in_if  in_if ();
  udrb_out_if out_if ();

  uart_dual_ring_buffer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predicts every result and compares; only the counts come back here
  udrb_ring_monitor u_ring_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .refused_o    (refused),
    .dropped_o    (dropped)
  );

  always #5 clk_i = ~clk_i;

  // receiver side: back-pressure at the current stall rate
  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // hang detection: any request or result moving resets the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("no request or result moved for %0d cycles", HangLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one request and hold it until taken; valid stays up between
  // back-to-back requests so it is never dropped and raised in one step
  task automatic send_request(op_e op, data_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.data_in <= b;
    do @(posedge clk_i); while (!in_if.ready);
    sent_by_op[int'(op)]++;
  endtask

  // pause the sender until every outstanding result has come back;
  // the first edge lets the monitor count a request taken on this one
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // bursts of related traffic so the rings both fill up and run dry
  task automatic run_mixed_bursts(int n_items);
    int         left;
    int         len;
    int         roll;
    burst_mix_e mix;
    op_e        op;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(4, 40);
      mix = burst_mix_e'($urandom_range(0, 3));
      for (int i = 0; i < len && left > 0; i++) begin
        roll = $urandom_range(0, 99);
        case (mix)
          MIX_UNIFORM: op = op_e'(roll % 4);
          MIX_FILL: begin
            op = (roll < 45) ? OP_HOST_WRITE :
                 (roll < 90) ? OP_LINE_RX    :
                 (roll < 95) ? OP_HOST_READ  : OP_LINE_DONE;
          end
          MIX_DRAIN: begin
            op = (roll < 45) ? OP_HOST_READ  :
                 (roll < 90) ? OP_LINE_DONE  :
                 (roll < 95) ? OP_HOST_WRITE : OP_LINE_RX;
          end
          default: begin
            // transmit streaming: writes chased by done events
            op = (roll < 50) ? OP_HOST_WRITE : OP_LINE_DONE;
          end
        endcase
        send_request(op, data_t'($urandom_range(0, 255)));
        left--;
      end
    end
  endtask

  initial begin
    int writes_left;
    int rx_left;

    // every input known from time zero
    in_if.valid   = 1'b0;
    in_if.op      = OP_HOST_WRITE;
    in_if.data_in = '0;
    out_if.ready  = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-ring corner cases first
    send_request(OP_HOST_READ, 8'hFF);   // read from empty receive ring
    send_request(OP_LINE_DONE, 8'h00);   // done while idle and empty
    // first write wakes the transmitter and goes straight to the line
    send_request(OP_HOST_WRITE, 8'h00);
    send_request(OP_HOST_WRITE, 8'hFF);
    send_request(OP_HOST_WRITE, 8'hA5);
    send_request(OP_LINE_DONE, 8'hFF);
    send_request(OP_LINE_DONE, 8'h00);
    // ring empty now: this done puts the transmitter back to idle
    send_request(OP_LINE_DONE, 8'h00);
    send_request(OP_LINE_DONE, 8'h00);
    send_request(OP_HOST_WRITE, 8'h5A);  // restart from idle
    send_request(OP_LINE_DONE, 8'h00);
    // receive side with extreme byte values
    send_request(OP_LINE_RX, 8'h00);
    send_request(OP_LINE_RX, 8'hFF);
    send_request(OP_LINE_RX, 8'h5A);
    send_request(OP_LINE_RX, 8'hA5);
    repeat (4) send_request(OP_HOST_READ, 8'h00);
    send_request(OP_HOST_READ, 8'h00);   // empty again
    wait_for_results();

    // overflow both rings: writes past the refusal point, line bytes
    // past the full point, interleaved at random
    writes_left = FillBytes;
    rx_left     = FillBytes;
    while (writes_left + rx_left > 0) begin
      if (rx_left == 0 || (writes_left > 0 && $urandom_range(0, 1) == 1)) begin
        send_request(OP_HOST_WRITE, data_t'($urandom_range(0, 255)));
        writes_left--;
      end else begin
        send_request(OP_LINE_RX, data_t'($urandom_range(0, 255)));
        rx_left--;
      end
    end
    wait_for_results();

    // random traffic under four pacing regimes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      run_mixed_bursts(PhaseItems);
      wait_for_results();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (TailCycles) @(posedge clk_i);

    $display("sent %0d requests: %0d writes, %0d reads, %0d line bytes, %0d done events",
             sent_by_op[0] + sent_by_op[1] + sent_by_op[2] + sent_by_op[3],
             sent_by_op[int'(OP_HOST_WRITE)], sent_by_op[int'(OP_HOST_READ)],
             sent_by_op[int'(OP_LINE_RX)], sent_by_op[int'(OP_LINE_DONE)]);
    $display("checked %0d results, %0d writes refused on a full ring, %0d line bytes dropped",
             checked, refused, dropped);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
